/* rtl/pcxrle_pkg.sv */
package pcxrle_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_LINES  = 1024;
  localparam int unsigned MAX_PLANES = 4;

  localparam int unsigned COL_W   = 11;
  localparam int unsigned ROW_W   = 11;
  localparam int unsigned PLANE_W = 2;
  localparam int unsigned PCNT_W  = 3;
  localparam int unsigned RUN_W   = 6;
  localparam int unsigned ADDR_W  = 22;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CIDX_W  = 2;

  localparam logic [DATA_W-1:0] RUN_MARK = 8'd192;

  localparam logic [CIDX_W-1:0] REG_LINE_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_LINE_COUNT  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_PLANE_COUNT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NORM,
    ST_MUL,
    ST_EMIT
  } state_t;

endpackage

/* rtl/pcx_rle_plane_decoder.sv */
// PCX run-length plane decoder.
// The input channel (in_valid, in_ready, in_coded_byte) takes one coded byte
// per item. The result channel (out_valid, out_ready and the payload ports)
// gives one item per pixel write: buffer address, value, a flag on the last
// write caused by the byte, and a flag on the write that ends the image.
// The configuration port writes line width, line count and plane count at
// indices 0, 1 and 2; indices beyond are ignored. The user must write them
// only while the block is idle; the block does not enforce it. A count byte
// is taken and causes no output. A byte that writes pixels goes through
// setup steps (accept, position update, row base multiply) and then writes
// one pixel per cycle while no waiting output write stalls the loop. The row
// base comes from one 11 by 11 bit multiplier and every address from one
// sum. in_ready is high only while the sequencer is idle. A finished write
// waits in the output register; while it waits and out_ready is low the
// pixel loop stalls; the next byte may be accepted while that write waits.
// Synchronous reset clears position, run state and the output valid, and sets
// all three registers to 1. Bytes after the image end are taken and dropped.
module pcx_rle_plane_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pcxrle_pkg::DATA_W-1:0] in_coded_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pcxrle_pkg::ADDR_W-1:0] out_buffer_address,
  output logic [pcxrle_pkg::DATA_W-1:0] out_pixel_value,
  output logic                         out_last_of_run,
  output logic                         out_image_done,
  input  logic                         cfg_we,
  input  logic [pcxrle_pkg::CIDX_W-1:0] cfg_index,
  input  logic [pcxrle_pkg::CFG_W-1:0]  cfg_wdata
);
  import pcxrle_pkg::*;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]   width_reg_r, lines_reg_r;
  logic [PCNT_W-1:0]  planes_reg_r;
  logic [COL_W-1:0]   w_eff, l_eff;
  logic [PCNT_W-1:0]  p_eff;

  logic               cw_r, cw_nxt;
  logic [RUN_W-1:0]   run_r, run_nxt;
  logic [RUN_W-1:0]   cnt_r, cnt_nxt;
  logic [DATA_W-1:0]  val_r, val_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [PLANE_W-1:0] plane_r, plane_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               fin_r, fin_nxt;
  logic [ADDR_W-1:0]  rowbase_r;

  logic               out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [DATA_W-1:0]  out_val_r;
  logic               out_last_r, out_done_r;

  logic               accept;
  logic               load;
  logic               start_run;
  logic               norm_fin;
  logic               emit_end;
  logic [ADDR_W-1:0]  pix_addr;
  logic [COL_W-1:0]   col_inc;
  logic [PCNT_W-1:0]  n_plane;
  logic [ROW_W-1:0]   n_row;
  logic               n_fin;
  logic [2*COL_W-1:0] prod;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign load     = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    if (width_reg_r == '0) begin
      w_eff = COL_W'(1);
    end else if (width_reg_r > CFG_W'(MAX_WIDTH)) begin
      w_eff = COL_W'(MAX_WIDTH);
    end else begin
      w_eff = width_reg_r;
    end
    if (lines_reg_r == '0) begin
      l_eff = ROW_W'(1);
    end else if (lines_reg_r > CFG_W'(MAX_LINES)) begin
      l_eff = ROW_W'(MAX_LINES);
    end else begin
      l_eff = lines_reg_r;
    end
    if (planes_reg_r == '0) begin
      p_eff = PCNT_W'(1);
    end else if (planes_reg_r > PCNT_W'(MAX_PLANES)) begin
      p_eff = PCNT_W'(MAX_PLANES);
    end else begin
      p_eff = planes_reg_r;
    end
  end

  always_comb begin
    start_run = 1'b0;
    if (accept && !fin_r) begin
      if (cw_r) begin
        start_run = (run_r != '0);
      end else begin
        start_run = (in_coded_byte < RUN_MARK);
      end
    end
  end

  // Position normalization before the first write of a run.
  always_comb begin
    n_plane  = {1'b0, plane_r};
    n_row    = row_r;
    n_fin    = fin_r;
    if (col_r >= w_eff) begin
      n_plane = n_plane + PCNT_W'(1);
      if (n_plane >= p_eff) begin
        n_plane = '0;
        n_row   = n_row + ROW_W'(1);
        if (n_row >= l_eff) begin
          n_fin = 1'b1;
        end
      end
    end
    if (!n_fin && (n_plane >= p_eff)) begin
      n_plane = '0;
      n_row   = n_row + ROW_W'(1);
      if (n_row >= l_eff) begin
        n_fin = 1'b1;
      end
    end
    if (!n_fin && (n_row >= l_eff)) begin
      n_fin = 1'b1;
    end
    norm_fin = n_fin;
  end

  assign prod     = row_r * w_eff;
  assign pix_addr = rowbase_r + ADDR_W'({col_r, 2'b00}) + ADDR_W'(plane_r);
  assign col_inc  = col_r + COL_W'(1);
  assign emit_end = (col_inc >= w_eff) || (cnt_r == RUN_W'(1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start_run) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        state_nxt = norm_fin ? ST_IDLE : ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (load && emit_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cw_nxt        = cw_r;
    run_nxt       = run_r;
    cnt_nxt       = cnt_r;
    val_nxt       = val_r;
    col_nxt       = col_r;
    plane_nxt     = plane_r;
    row_nxt       = row_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (accept && !fin_r) begin
          val_nxt = in_coded_byte;
          if (cw_r) begin
            cw_nxt  = 1'b0;
            run_nxt = '0;
            cnt_nxt = run_r;
          end else if (in_coded_byte >= RUN_MARK) begin
            cw_nxt  = 1'b1;
            run_nxt = RUN_W'(in_coded_byte - RUN_MARK);
          end else begin
            cnt_nxt = RUN_W'(1);
          end
        end
      end
      ST_NORM: begin
        if (col_r >= w_eff) begin
          col_nxt = '0;
        end
        plane_nxt = n_plane[PLANE_W-1:0];
        row_nxt   = n_row;
        fin_nxt   = n_fin;
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          cnt_nxt       = cnt_r - RUN_W'(1);
          col_nxt       = col_inc;
          if (col_inc >= w_eff) begin
            col_nxt = '0;
            if (({1'b0, plane_r} + PCNT_W'(1)) >= p_eff) begin
              plane_nxt = '0;
              row_nxt   = row_r + ROW_W'(1);
              if ((row_r + ROW_W'(1)) >= l_eff) begin
                fin_nxt = 1'b1;
              end
            end else begin
              plane_nxt = plane_r + PLANE_W'(1);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      width_reg_r  <= CFG_W'(1);
      lines_reg_r  <= CFG_W'(1);
      planes_reg_r <= PCNT_W'(1);
      cw_r         <= 1'b0;
      run_r        <= '0;
      col_r        <= '0;
      plane_r      <= '0;
      row_r        <= '0;
      fin_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cw_r        <= cw_nxt;
      run_r       <= run_nxt;
      col_r       <= col_nxt;
      plane_r     <= plane_nxt;
      row_r       <= row_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_LINE_WIDTH:  width_reg_r  <= cfg_wdata;
          REG_LINE_COUNT:  lines_reg_r  <= cfg_wdata;
          REG_PLANE_COUNT: planes_reg_r <= cfg_wdata[PCNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    val_r <= val_nxt;
    if (state_r == ST_MUL) begin
      rowbase_r <= {prod[ADDR_W-3:0], 2'b00};
    end
    if (load) begin
      out_addr_r <= pix_addr;
      out_val_r  <= val_r;
      out_last_r <= emit_end;
      out_done_r <= fin_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_buffer_address = out_addr_r;
  assign out_pixel_value    = out_val_r;
  assign out_last_of_run    = out_last_r;
  assign out_image_done     = out_done_r;

endmodule
